### src/tsd_pkg.sv
// Shared types, constants and calendar functions for the timestamp difference block.
package tsd_pkg;

  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned HOUR_W    = 5;
  localparam int unsigned MINUTE_W  = 6;
  localparam int unsigned MILLIS_W  = 16;
  localparam int unsigned DIFF_W    = 50;
  localparam int unsigned DAYS_W    = 24;
  localparam int unsigned DDAYS_W   = DAYS_W + 1;
  localparam int unsigned INTRA_W   = 27;
  localparam int unsigned DINTRA_W  = INTRA_W + 1;
  localparam int unsigned PROD_W    = DDAYS_W + DINTRA_W;
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 56;

  localparam int unsigned DEF_QUEUE_DEPTH = 4;

  localparam logic [INTRA_W-1:0] MS_PER_HOUR   = INTRA_W'(3600000);
  localparam logic [INTRA_W-1:0] MS_PER_MINUTE = INTRA_W'(60000);
  localparam logic signed [DINTRA_W-1:0] MS_PER_DAY = DINTRA_W'(86400000);

  localparam logic [MONTH_W-1:0] MONTH_FIRST = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_LAST  = MONTH_W'(12);

  // One stamp after the first front stage.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [7:0]         q100;
    logic [7:0]         qu100;
    logic [5:0]         qu400;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [INTRA_W-1:0] intra;
  } tsd_stamp_t;

  // One item as it waits in the queue.
  typedef struct packed {
    logic               invalid;
    logic [DAYS_W-1:0]  days1;
    logic [DAYS_W-1:0]  days2;
    logic [INTRA_W-1:0] intra1;
    logic [INTRA_W-1:0] intra2;
  } tsd_entry_t;

  // Floor of x / 100 for x below 25600, by reciprocal multiplication.
  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'd5243;
    return p[26:19];
  endfunction

  // Days before the first of the month, month index 0 to 11.
  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
    logic [8:0] d;
    unique case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    if (leap && idx >= 4'd2) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

### src/tsd_front.sv
// Front end: accepts beats, checks months and turns each stamp into day and intraday counts.
module tsd_front
  import tsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IN_DATA_W-1:0] in_data,
  output logic                 push,
  output tsd_entry_t           push_entry,
  input  logic                 queue_full
);

  logic       s1_vld_r, s1_vld_nxt;
  logic       s2_vld_r, s2_vld_nxt;
  logic       en;
  tsd_stamp_t s1a_r, s1a_nxt, s1b_r, s1b_nxt;
  logic       s1_inv_r, s1_inv_nxt;
  tsd_entry_t s2_r, s2_nxt;

  function automatic tsd_stamp_t stage1(input logic [49:0] f);
    tsd_stamp_t    s;
    logic [14:0]   y15;
    logic [14:0]   up400;
    y15     = 15'(f[13:0]);
    up400   = 15'(y15 + 15'd399);
    s.year  = f[13:0];
    s.q100  = div100(y15);
    s.qu100 = div100(15'(y15 + 15'd99));
    s.qu400 = 6'(div100(15'(up400 >> 2)));
    s.month = f[17:14];
    s.day   = f[22:18];
    s.intra = INTRA_W'(INTRA_W'(f[27:23]) * MS_PER_HOUR)
            + INTRA_W'(INTRA_W'(f[33:28]) * MS_PER_MINUTE)
            + INTRA_W'(f[49:34]);
    return s;
  endfunction

  function automatic logic month_bad(input logic [MONTH_W-1:0] m);
    return (m < MONTH_FIRST) || (m > MONTH_LAST);
  endfunction

  function automatic logic [DAYS_W-1:0] stage2(input tsd_stamp_t s);
    logic [YEAR_W-1:0] r100;
    logic              leap;
    logic [8:0]        cum;
    logic [DAYS_W-1:0] d;
    r100 = YEAR_W'(s.year - YEAR_W'(YEAR_W'(s.q100) * YEAR_W'(100)));
    leap = ((s.year[1:0] == 2'd0) && (r100 != '0)) ||
           ((r100 == '0) && (s.q100[1:0] == 2'd0));
    cum  = cum_days(leap, 4'(s.month - MONTH_FIRST));
    d    = DAYS_W'(DAYS_W'(s.year) * DAYS_W'(365))
         + DAYS_W'((DAYS_W'(s.year) + DAYS_W'(3)) >> 2)
         - DAYS_W'(s.qu100) + DAYS_W'(s.qu400)
         + DAYS_W'(cum) + DAYS_W'(s.day) - DAYS_W'(1);
    return d;
  endfunction

  assign en       = !s2_vld_r || !queue_full;
  assign in_ready = en;

  assign s1_vld_nxt = in_valid;
  assign s1a_nxt    = stage1(in_data[49:0]);
  assign s1b_nxt    = stage1(in_data[99:50]);
  assign s1_inv_nxt = month_bad(in_data[17:14]) || month_bad(in_data[67:64]);

  assign s2_vld_nxt    = s1_vld_r;
  assign s2_nxt.invalid = s1_inv_r;
  assign s2_nxt.days1  = stage2(s1a_r);
  assign s2_nxt.days2  = stage2(s1b_r);
  assign s2_nxt.intra1 = s1a_r.intra;
  assign s2_nxt.intra2 = s1b_r.intra;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1a_r    <= s1a_nxt;
      s1b_r    <= s1b_nxt;
      s1_inv_r <= s1_inv_nxt;
      s2_r     <= s2_nxt;
    end
  end

  assign push       = s2_vld_r && !queue_full;
  assign push_entry = s2_r;

endmodule

### src/tsd_queue.sv
// Small register queue between the front end and the back end.
module tsd_queue
  import tsd_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tsd_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output tsd_entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  tsd_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### src/tsd_back.sv
// Back end: forms day and intraday differences, scales days to ms, adds; zero if invalid.
module tsd_back
  import tsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              avail,
  input  tsd_entry_t        head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIFF_W-1:0] out_diff,
  output logic              out_invalid
);

  logic en;

  logic                       b1_vld_r, b1_vld_nxt;
  logic                       b1_inv_r, b1_inv_nxt;
  logic signed [DDAYS_W-1:0]  b1_dd_r, b1_dd_nxt;
  logic signed [DINTRA_W-1:0] b1_di_r, b1_di_nxt;

  logic                       b2_vld_r, b2_vld_nxt;
  logic                       b2_inv_r;
  logic signed [PROD_W-1:0]   b2_prod_r, b2_prod_nxt;
  logic signed [DINTRA_W-1:0] b2_di_r;

  logic                       out_vld_r, out_vld_nxt;
  logic [DIFF_W-1:0]          out_diff_r, out_diff_nxt;
  logic                       out_inv_r;

  assign en  = !out_vld_r || out_ready;
  assign pop = en && avail;

  assign b1_vld_nxt = avail;
  assign b1_inv_nxt = head.invalid;
  assign b1_dd_nxt  = DDAYS_W'($signed(head.days2)) - DDAYS_W'($signed(head.days1));
  assign b1_di_nxt  = $signed({1'b0, head.intra2}) - $signed({1'b0, head.intra1});

  assign b2_vld_nxt  = b1_vld_r;
  assign b2_prod_nxt = PROD_W'(b1_dd_r * MS_PER_DAY);

  assign out_vld_nxt  = b2_vld_r;
  assign out_diff_nxt = b2_inv_r ? '0
                      : DIFF_W'(b2_prod_r[DIFF_W-1:0] + DIFF_W'(b2_di_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r  <= 1'b0;
      b2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      b1_vld_r  <= b1_vld_nxt;
      b2_vld_r  <= b2_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_inv_r   <= b1_inv_nxt;
      b1_dd_r    <= b1_dd_nxt;
      b1_di_r    <= b1_di_nxt;
      b2_inv_r   <= b1_inv_r;
      b2_prod_r  <= b2_prod_nxt;
      b2_di_r    <= b1_di_r;
      out_inv_r  <= b2_inv_r;
      out_diff_r <= out_diff_nxt;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_diff    = out_diff_r;
  assign out_invalid = out_inv_r;

endmodule

### src/timestamp_difference.sv
// Top level of the Gregorian timestamp difference block.
// Each input beat carries two stamps and yields one output beat with the signed
// difference, second minus first, in milliseconds, or zero with the invalid flag
// set when either month lies outside 1 to 12. The block takes one beat per clock
// cycle while the front end is not stalled by a full queue. A beat passes two front
// stages, the queue and three back stages; the back end holds the single
// day-to-millisecond multiply. The queue of QUEUE_DEPTH entries lets the front
// keep accepting while the output is held, until the queue fills.
module timestamp_difference
  import tsd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // first_year, first_month, first_day, first_hour, first_minute, first_millis,
  // second_year, second_month, second_day, second_hour, second_minute,
  // second_millis, then zero padding.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // difference_ms, then zero padding.
  output logic [OUT_DATA_W-1:0] out_tdata,
  // input_invalid.
  output logic                  out_tuser
);

  logic              push;
  tsd_entry_t        push_entry;
  logic              queue_full;
  logic              pop;
  logic              not_empty;
  tsd_entry_t        head;
  logic [DIFF_W-1:0] diff;

  tsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_data    (in_tdata),
    .push       (push),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  tsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  tsd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .avail       (not_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_diff    (diff),
    .out_invalid (out_tuser)
  );

  assign out_tdata = {{(OUT_DATA_W - DIFF_W){1'b0}}, diff};

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the timestamp difference block, with its own calendar predictor.
module testbench;
  import tsd_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned RANDOM_ITEMS = 250;
  localparam int CUM_DAYS[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  // Members are listed from the highest bit down, so year sits in the lowest bits.
  typedef struct packed {
    logic [MILLIS_W-1:0] millis;
    logic [MINUTE_W-1:0] minute;
    logic [HOUR_W-1:0]   hour;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
  } stamp_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic                     invalid;
  } diff_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  diff_result_t expected_diffs[$];
  int errors = 0;
  int pairs_sent = 0;
  int results_seen = 0;
  int invalid_sent = 0;
  int negative_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_ticket = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  timestamp_difference u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic stamp_t mk(input int y, input int mo, input int d, input int h,
                                input int mi, input int ms);
    stamp_t s;
    s.year   = YEAR_W'(y);
    s.month  = MONTH_W'(mo);
    s.day    = DAY_W'(d);
    s.hour   = HOUR_W'(h);
    s.minute = MINUTE_W'(mi);
    s.millis = MILLIS_W'(ms);
    return s;
  endfunction

  // Milliseconds from 1 January of year 0 to the stamp; the month must be 1 to 12.
  function automatic longint stamp_millis(input stamp_t s);
    longint y;
    longint doy;
    longint days;
    y = longint'(s.year);
    doy = CUM_DAYS[int'(s.month) - 1] + longint'(s.day) - 1;
    if ((((y % 4) == 0) && ((y % 100) != 0) || ((y % 400) == 0)) && s.month > 2) begin
      doy = doy + 1;
    end
    days = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + doy;
    return days * 64'd86400000 + longint'(s.hour) * 3600000 + longint'(s.minute) * 60000
           + longint'(s.millis);
  endfunction

  function automatic stamp_t rand_stamp();
    stamp_t s;
    s.year   = ($urandom_range(0, 3) == 0) ? YEAR_W'($urandom_range(0, 16383))
                                           : YEAR_W'($urandom_range(1, 9999));
    s.month  = ($urandom_range(0, 19) == 0) ? MONTH_W'($urandom_range(0, 15))
                                            : MONTH_W'($urandom_range(1, 12));
    s.day    = ($urandom_range(0, 9) == 0) ? DAY_W'($urandom_range(0, 31))
                                           : DAY_W'($urandom_range(1, 31));
    s.hour   = ($urandom_range(0, 9) == 0) ? HOUR_W'($urandom_range(0, 31))
                                           : HOUR_W'($urandom_range(0, 23));
    s.minute = ($urandom_range(0, 9) == 0) ? MINUTE_W'($urandom_range(0, 63))
                                           : MINUTE_W'($urandom_range(0, 59));
    s.millis = ($urandom_range(0, 9) == 0) ? MILLIS_W'($urandom_range(0, 65535))
                                           : MILLIS_W'($urandom_range(0, 59999));
    return s;
  endfunction

  task automatic send_pair(input stamp_t first, input stamp_t second);
    diff_result_t want;
    want.invalid = first.month < MONTH_FIRST || first.month > MONTH_LAST ||
                   second.month < MONTH_FIRST || second.month > MONTH_LAST;
    want.diff = want.invalid ? '0 : DIFF_W'(stamp_millis(second) - stamp_millis(first));
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, second, first};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_diffs.push_back(want);
    pairs_sent++;
    if (want.invalid) invalid_sent++;
    if (want.diff < 0) negative_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_diffs.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_pair(mk(2024, 3, 15, 12, 30, 30000), mk(2024, 3, 15, 12, 30, 30000));
    send_pair(mk(2023, 12, 31, 23, 59, 59999), mk(2024, 1, 1, 0, 0, 0));
    send_pair(mk(1900, 2, 28, 0, 0, 0), mk(1900, 3, 1, 0, 0, 0));
    send_pair(mk(2000, 2, 28, 0, 0, 0), mk(2000, 3, 1, 0, 0, 0));
    send_pair(mk(2023, 2, 29, 6, 0, 0), mk(2024, 2, 29, 6, 0, 0));
    send_pair(mk(2100, 2, 29, 0, 0, 0), mk(2100, 3, 1, 0, 0, 0));
    send_pair(mk(1600, 12, 31, 0, 0, 0), mk(1601, 1, 1, 0, 0, 0));
    send_pair(mk(0, 1, 1, 0, 0, 0), mk(1, 1, 1, 0, 0, 0));
    send_pair(mk(0, 1, 0, 0, 0, 0), mk(16383, 12, 31, 31, 63, 65535));
    send_pair(mk(16383, 12, 31, 31, 63, 65535), mk(0, 1, 0, 0, 0, 0));
    send_pair(mk(9999, 12, 31, 23, 59, 59999), mk(1, 1, 1, 0, 0, 0));
    send_pair(mk(10000, 6, 15, 12, 0, 0), mk(16383, 6, 15, 12, 0, 0));
    send_pair(mk(2020, 12, 0, 31, 63, 65535), mk(2021, 1, 31, 0, 0, 0));
    send_pair(mk(2019, 4, 31, 24, 60, 60000), mk(2019, 5, 1, 0, 0, 0));
    send_pair(mk(2001, 0, 1, 0, 0, 0), mk(2002, 5, 1, 0, 0, 0));
    send_pair(mk(2001, 3, 1, 0, 0, 0), mk(2002, 13, 1, 0, 0, 0));
    send_pair(mk(2001, 15, 1, 0, 0, 0), mk(2002, 15, 1, 0, 0, 0));
    send_pair(mk(2001, 14, 9, 3, 4, 5), mk(2001, 7, 9, 3, 4, 5));
    send_pair(mk(2001, 1, 1, 0, 0, 0), mk(2001, 0, 31, 31, 63, 65535));
    send_pair(mk(1996, 1, 1, 0, 0, 0), mk(2000, 1, 1, 0, 0, 0));
    send_pair(mk(16383, 2, 29, 0, 0, 1), mk(16384 - 1, 3, 1, 0, 0, 0));
    drain();
  endtask

  task automatic test_random(input int idle_pct, input int stall_pct);
    stamp_t a;
    stamp_t b;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      a = rand_stamp();
      b = rand_stamp();
      if ($urandom_range(0, 1) == 0) begin
        b.year = YEAR_W'(int'(a.year) + int'($urandom_range(0, 4)) - 2);
      end
      send_pair(a, b);
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_ticket <= hold_ticket + 1;
    repeat (40) send_pair(rand_stamp(), rand_stamp());
    drain();
  endtask

  always @(posedge clk) begin
    diff_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_diffs.size() == 0) begin
        $error("result beat with no expectation: difference_ms %0d input_invalid %0b",
               $signed(out_tdata[DIFF_W-1:0]), out_tuser);
        errors++;
      end else begin
        want = expected_diffs.pop_front();
        if (out_tdata[DIFF_W-1:0] !== want.diff) begin
          $error("difference_ms: expected %0d, actual %0d", want.diff,
                 $signed(out_tdata[DIFF_W-1:0]));
          errors++;
        end
        if (out_tuser !== want.invalid) begin
          $error("input_invalid: expected %0b, actual %0b", want.invalid, out_tuser);
          errors++;
        end
      end
    end
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $error("no beat moved for %0d cycles", STALL_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(0, 0);
    test_random(59, 0);
    test_random(0, 59);
    test_random(22, 22);
    test_backpressure();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d stamp pairs: calendar edge cases, four idle mixes and a long output hold.",
             pairs_sent);
    $display("Checked %0d results, %0d with a bad month and %0d with a negative difference.",
             results_seen, invalid_sent, negative_sent);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
